// File: design/label_bounding_box_accumulator_top_macros.svh
// Assertion macros shared by the label bounding box accumulator RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef LABEL_BOUNDING_BOX_ACCUMULATOR_TOP_MACROS_SVH
`define LABEL_BOUNDING_BOX_ACCUMULATOR_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LBBA_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbba: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define LBBA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbba: next-cycle check failed");

`endif

// File: design/lbba_pkg.sv
// Package for the label bounding box accumulator.
// Holds the field widths, command and register codes, and payload structs.
package lbba_pkg;

  localparam int LABEL_W     = 8;
  localparam int LABEL_COUNT = 256;
  localparam int MAX_DIM     = 4096;
  localparam int DIM_W       = 13;
  localparam int POS_W       = 12;
  localparam int CMD_W       = 2;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FRAME = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [LABEL_W-1:0] label;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] min_row;
    logic [POS_W-1:0] min_col;
    logic [POS_W-1:0] max_row;
    logic [POS_W-1:0] max_col;
    logic             label_seen;
    logic             frame_complete;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0] rmin;
    logic [POS_W-1:0] cmin;
    logic [POS_W-1:0] rmax;
    logic [POS_W-1:0] cmax;
  } box_t;

endpackage

// File: design/label_bounding_box_accumulator_top.sv
// Label bounding box accumulator: one module with the box memory and seen flags.
// Depends on lbba_pkg and label_bounding_box_accumulator_top_macros.svh.
//
// The block takes one item per cycle. A pixel advances the raster position at
// transfer and updates its label's box in the box memory in the cycle after,
// with the last write forwarded so that back-to-back pixels of one label see it.
// A query's result passes from the second stage into the output register.
// The only back-pressure is a query that finds the output register full and
// stalled; it then holds the second stage and the input stalls until the
// result is taken. Seen flags live in flip-flops and are all cleared at once
// by a start-of-frame item, so no clearing pass is needed after reset.
`include "label_bounding_box_accumulator_top_macros.svh"

module label_bounding_box_accumulator_top
  import lbba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic [DIM_W-1:0]       row_count;
  logic [DIM_W-1:0]       col_count;
  logic [DIM_W-1:0]       row_pos;
  logic [DIM_W-1:0]       col_pos;
  logic                   frame_done;
  logic [LABEL_COUNT-1:0] seen_flags;

  box_t                   box_mem [LABEL_COUNT];
  box_t                   rd_box;

  logic                   s1_write;
  logic                   s1_query;
  logic [LABEL_W-1:0]     s1_label;
  logic [POS_W-1:0]       s1_row;
  logic [POS_W-1:0]       s1_col;
  logic                   s1_seen;
  logic                   s1_done;

  logic                   fwd_valid;
  logic [LABEL_W-1:0]     fwd_label;
  box_t                   fwd_box;

  logic                   item_accept;
  logic                   s1_go;
  logic                   wrap_now;
  logic [DIM_W-1:0]       c0;
  logic [DIM_W-1:0]       r0;
  logic [DIM_W-1:0]       c1;
  logic [DIM_W-1:0]       r1;
  logic                   placed;
  logic                   end_row;
  logic                   tracked;
  logic [DIM_W-1:0]       cfg_clamped;
  box_t                   cur_box;
  box_t                   new_box;

  assign s1_go       = !(s1_query && result_valid && result_stall);
  assign item_stall  = !s1_go;
  assign item_accept = item_valid && s1_go;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = DIM_W'(1);
    end else if (cfg_data > DIM_W'(MAX_DIM)) begin
      cfg_clamped = DIM_W'(MAX_DIM);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  assign wrap_now = col_pos >= col_count;
  assign c0       = wrap_now ? '0 : col_pos;
  assign r0       = wrap_now ? row_pos + DIM_W'(1) : row_pos;
  assign placed   = r0 < row_count;
  assign c1       = c0 + DIM_W'(1);
  assign r1       = r0 + DIM_W'(1);
  assign end_row  = c1 >= col_count;
  assign tracked  = item_accept && (item.cmd == CMD_PIXEL) && !frame_done && placed
                    && (item.label != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= DIM_W'(MAX_DIM);
      col_count <= DIM_W'(MAX_DIM);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROW_COUNT: row_count <= cfg_clamped;
        CFG_COL_COUNT: col_count <= cfg_clamped;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos    <= '0;
      col_pos    <= '0;
      frame_done <= 1'b0;
      seen_flags <= '0;
    end else if (item_accept) begin
      if (item.cmd == CMD_FRAME) begin
        row_pos    <= '0;
        col_pos    <= '0;
        frame_done <= 1'b0;
        seen_flags <= '0;
      end else if (item.cmd == CMD_PIXEL && !frame_done) begin
        if (!placed) begin
          row_pos    <= r0;
          col_pos    <= c0;
          frame_done <= 1'b1;
        end else if (end_row) begin
          row_pos    <= r1;
          col_pos    <= '0;
          frame_done <= r1 >= row_count;
        end else begin
          row_pos <= r0;
          col_pos <= c1;
        end
        if (tracked) begin
          seen_flags[item.label] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_write <= 1'b0;
      s1_query <= 1'b0;
    end else if (s1_go) begin
      s1_write <= tracked;
      s1_query <= item_accept && (item.cmd == CMD_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_label <= item.label;
      s1_row   <= POS_W'(r0);
      s1_col   <= POS_W'(c0);
      s1_seen  <= seen_flags[item.label];
      s1_done  <= frame_done;
      rd_box   <= box_mem[item.label];
    end
  end

  assign cur_box = (fwd_valid && fwd_label == s1_label) ? fwd_box : rd_box;

  always_comb begin
    new_box.rmin = (!s1_seen || s1_row < cur_box.rmin) ? s1_row : cur_box.rmin;
    new_box.rmax = (!s1_seen || s1_row > cur_box.rmax) ? s1_row : cur_box.rmax;
    new_box.cmin = (!s1_seen || s1_col < cur_box.cmin) ? s1_col : cur_box.cmin;
    new_box.cmax = (!s1_seen || s1_col > cur_box.cmax) ? s1_col : cur_box.cmax;
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      box_mem[s1_label] <= new_box;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_write) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      fwd_label <= s1_label;
      fwd_box   <= new_box;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= s1_query;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_query && (!result_valid || !result_stall)) begin
      result.min_row        <= s1_seen ? cur_box.rmin : '0;
      result.min_col        <= s1_seen ? cur_box.cmin : '0;
      result.max_row        <= s1_seen ? cur_box.rmax : '0;
      result.max_col        <= s1_seen ? cur_box.cmax : '0;
      result.label_seen     <= s1_seen;
      result.frame_complete <= s1_done;
    end
  end

  // A result for an unseen label carries an all-zero box.
  `LBBA_ASSERT_NOW(unseen_box_zero, result_valid && !result.label_seen,
    result.min_row == '0 && result.min_col == '0 && result.max_row == '0 &&
    result.max_col == '0)

  // A seen label's box is never inverted.
  `LBBA_ASSERT_NOW(seen_box_ordered, result_valid && result.label_seen,
    result.min_row <= result.max_row && result.min_col <= result.max_col)

  // Once the frame is done it stays done until a new frame starts.
  `LBBA_ASSERT_NEXT(frame_done_sticks,
    frame_done && !(item_accept && item.cmd == CMD_FRAME), frame_done)

  // A start-of-frame transfer leaves every seen flag cleared.
  `LBBA_ASSERT_NEXT(frame_clears_seen, item_accept && item.cmd == CMD_FRAME,
    seen_flags == '0)

  // Background is never tracked.
  `LBBA_ASSERT_NOW(background_unseen, 1'b1, seen_flags[0] == 1'b0)

endmodule
